// ===== rtl/indexed_list_store_core_macros.svh =====
// Assertion helpers for the indexed list store core.
`ifndef INDEXED_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_STORE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ILS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ILS_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ILS_ASSERT(lbl, clk, rstn, prop, msg)

`define ILS_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== rtl/ils_pkg.sv =====
package ils_pkg;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_AT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  localparam logic [VAL_W-1:0] READ_MISS = '1;

  typedef enum logic [2:0] {
    OP_GET,
    OP_ADD_HEAD,
    OP_ADD_TAIL,
    OP_ADD_AT,
    OP_DELETE,
    OP_BAD
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             hit;
    logic             rejected;
    logic [CNT_W-1:0] count;
    logic             empty;
  } res_t;

endpackage

// ===== rtl/ils_front.sv =====
module ils_front (
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [ils_pkg::CMD_W-1:0]   cmd_i,
  input  logic [ils_pkg::POS_W-1:0]   pos_i,
  input  logic [ils_pkg::VAL_W-1:0]   value_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output ils_pkg::op_t                q_op_o
);

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  always_comb begin
    q_op_o.pos   = pos_i;
    q_op_o.value = value_i;
    unique case (cmd_i)
      ils_pkg::CMD_GET:      q_op_o.kind = ils_pkg::OP_GET;
      ils_pkg::CMD_ADD_HEAD: q_op_o.kind = ils_pkg::OP_ADD_HEAD;
      ils_pkg::CMD_ADD_TAIL: q_op_o.kind = ils_pkg::OP_ADD_TAIL;
      ils_pkg::CMD_ADD_AT:   q_op_o.kind = ils_pkg::OP_ADD_AT;
      ils_pkg::CMD_DELETE:   q_op_o.kind = ils_pkg::OP_DELETE;
      default:               q_op_o.kind = ils_pkg::OP_BAD;
    endcase
  end

endmodule

// ===== rtl/ils_queue.sv =====
module ils_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ils_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output ils_pkg::op_t op_o
);

  ils_pkg::op_t slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   fill_q, fill_d;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// ===== rtl/ils_back.sv =====
module ils_back #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ils_pkg::op_t  q_op_i,
  output logic          q_pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output ils_pkg::res_t res_o,
  output logic [CW-1:0] count_o
);

  localparam int unsigned PW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

  logic [ils_pkg::VAL_W-1:0] cells_q [DEPTH];
  logic [CW-1:0]             count_q, count_d;
  logic                      out_valid_q;
  ils_pkg::res_t             res_q, res_d;

  logic                      fire, ins, del, rej, hit, full;
  logic [PW-1:0]             pos_ext, cnt_ext, p;
  logic [ils_pkg::VAL_W-1:0] sel, rd;

  assign fire    = q_valid_i && (!out_valid_q || m_ready_i);
  assign q_pop_o = fire;
  assign pos_ext = PW'(q_op_i.pos);
  assign cnt_ext = PW'(count_q);
  assign full    = count_q == CW'(DEPTH);

  always_comb begin
    sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel = sel | ({ils_pkg::VAL_W{pos_ext == PW'(i)}} & cells_q[i]);
    end
  end

  always_comb begin
    ins = 1'b0;
    del = 1'b0;
    rej = 1'b0;
    hit = 1'b0;
    rd  = '0;
    p   = '0;
    unique case (q_op_i.kind)
      ils_pkg::OP_GET: begin
        if (pos_ext < cnt_ext) begin
          hit = 1'b1;
          rd  = sel;
        end else begin
          rej = 1'b1;
          rd  = ils_pkg::READ_MISS;
        end
      end
      ils_pkg::OP_ADD_HEAD: begin
        rej = full;
        ins = !full;
      end
      ils_pkg::OP_ADD_TAIL: begin
        rej = full;
        ins = !full;
        p   = cnt_ext;
      end
      ils_pkg::OP_ADD_AT: begin
        rej = full || (pos_ext > cnt_ext);
        ins = !rej;
        p   = pos_ext;
      end
      ils_pkg::OP_DELETE: begin
        rej = pos_ext >= cnt_ext;
        del = !rej;
        p   = pos_ext;
      end
      default: begin
        rej = 1'b1;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ins) begin
      count_d = count_q + CW'(1);
    end else if (del) begin
      count_d = count_q - CW'(1);
    end
    res_d.read_value = rd;
    res_d.hit        = hit;
    res_d.rejected   = rej;
    res_d.count      = ils_pkg::CNT_W'(count_d);
    res_d.empty      = count_d == '0;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ils_pkg::VAL_W-1:0] below, above;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_inner_lo
      assign below = cells_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = cells_q[i];
    end else begin : g_inner_hi
      assign above = cells_q[i+1];
    end
    always_ff @(posedge clk_i) begin
      if (fire) begin
        if (ins) begin
          if (PW'(i) == p) begin
            cells_q[i] <= q_op_i.value;
          end else if (PW'(i) > p) begin
            cells_q[i] <= below;
          end
        end else if (del && (PW'(i) >= p)) begin
          cells_q[i] <= above;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign res_o     = res_q;
  assign count_o   = count_q;

endmodule

// ===== rtl/indexed_list_store_core.sv =====
// Indexed list store: an ordered sequence of up to DEPTH signed 32-bit words.
// Commands arrive on the s_axis channel (cmd in tuser, position and value in
// tdata); each produces exactly one result word on m_axis, in order.
// Commands: get, add at head, add at tail, add before a position, delete at a
// position. Inserts and deletes shift every later entry in parallel across a
// row of registers, so one command completes per clock unless m_axis stalls.
// Path: a command accepted on s_axis is written into the queue, then passes
// through the cell row into the output register, where its result shows.
// Throughput: one command per cycle while m_axis_tready is high or no result waits.
// A two-word queue sits between the decode front and the cell row; the result
// is held in an output register, so the block keeps taking commands while a
// result waits, until the queue fills.
// When m_axis_tready is low the result holds and s_axis_tready drops once the
// queue is full. Reset empties the store, the queue and the output register;
// entry contents are not cleared and are never visible before being written.
// Out-of-range positions, inserts into a full store and unknown commands are
// flagged as rejected with no change; a rejected get returns -1.
`include "indexed_list_store_core_macros.svh"

module indexed_list_store_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[6:0], value[38:7]
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // read_value[31:0], hit, rejected, count[40:34], empty_res
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic          q_full, q_push, q_valid, q_pop;
  ils_pkg::op_t  push_op, head_op;
  ils_pkg::res_t res;
  logic [CntW-1:0] cnt;

  ils_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_i     (s_axis_tuser),
    .pos_i     (s_axis_tdata[6:0]),
    .value_i   (s_axis_tdata[38:7]),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_op_o    (push_op)
  );

  ils_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (head_op)
  );

  ils_back #(
    .DEPTH (DEPTH),
    .CW    (CntW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (head_op),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res),
    .count_o   (cnt)
  );

  assign m_axis_tdata = {6'd0, res.empty, res.count, res.rejected, res.hit, res.read_value};

  `ILS_ASSERT(a_hit_not_rejected, clk_i, rst_ni, m_axis_tvalid |-> !(res.hit && res.rejected), "hit and rejected both set")
  `ILS_ASSERT(a_empty_matches, clk_i, rst_ni, m_axis_tvalid |-> (res.empty == (cnt == '0)), "empty flag disagrees with count")
  `ILS_NEVER(a_count_bound, clk_i, rst_ni, cnt > CntW'(DEPTH), "count exceeds depth")

endmodule
